/* design/mandelbrot_pixel_shader_macros.svh */
// ----------------------------------------------------------------------------
// mandelbrot_pixel_shader_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_PIXEL_SHADER_MACROS_SVH
`define MANDELBROT_PIXEL_SHADER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, disabled while reset is asserted
`define MPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* design/mps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mps_pkg
// shared constants, register indexes, divider request and response types and a saturating add
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int WORD_W     = 64;
    localparam int DIV_W      = 64;
    localparam int STEP_W     = 7;
    localparam int LOG_W      = 32;
    localparam int LOG_FRAC   = 16;
    localparam int CENTRE_FRAC = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CIM    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd5;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  dvs;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    function automatic logic signed [WORD_W-1:0] sat_add(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            sat_add = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            sat_add = s[WORD_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

/* design/mps_mul32.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mps_mul32
// shared 32x32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module mps_mul32 (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_prod
);
    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

/* design/mps_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mps_div
// restoring divider, one quotient bit per cycle, prescaled divisor
// ----------------------------------------------------------------------------
module mps_div (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire mps_pkg::t_div_req i_req,
    output mps_pkg::t_div_rsp o_rsp
);
    import mps_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_dvs, n_dvs;
    logic [DIV_W-1:0]  r_quot, n_quot;
    logic [DIV_W-1:0]  rem_sel;
    logic              ge;

    always_comb begin
        ge      = r_rem >= r_dvs;
        rem_sel = ge ? (r_rem - r_dvs) : r_rem;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_quot  = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_rem  = i_req.rem;
            n_dvs  = i_req.dvs;
            n_quot = '0;
            n_cnt  = i_req.steps;
        end else if (r_busy) begin
            n_quot = {r_quot[DIV_W-2:0], ge};
            n_rem  = {rem_sel[DIV_W-2:0], 1'b0};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule
`default_nettype wire

/* design/mandelbrot_pixel_shader.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_pixel_shader
// one pixel at a time: coordinate mapping by restoring division, escape-time
// iteration with 64-bit fixed-point products built from four partial products
// on one shared 32x32 multiplier, then log2 by repeated squaring on the same
// multiplier and a final 8-bit division for the smooth brightness.
// one pixel in flight: the next transaction is accepted once the result has
// been taken.
// reset: synchronous active low; only state and configuration are reset.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_shader #(
    parameter int FRAC_BITS  = 28,
    parameter int ITER_BITS  = 16,
    parameter int COORD_BITS = 12
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic                                     i_cfg_we,
    input  wire logic [mps_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  wire logic [mps_pkg::CFG_DATA_W-1:0]           i_cfg_data,
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    // pixel_x, pixel_y
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    // colour, iteration_count
    output logic [((32+ITER_BITS+7)/8)*8-1:0]             m_axis_tdata,
    // escaped
    output logic                                          m_axis_tuser
);
    import mps_pkg::*;

    localparam int OUT_W  = ((32+ITER_BITS+7)/8)*8;
    localparam int SIZE_W = COORD_BITS + 1;
    localparam int CSHL   = (FRAC_BITS >= CENTRE_FRAC) ? FRAC_BITS - CENTRE_FRAC : 0;
    localparam int CSHR   = (FRAC_BITS <  CENTRE_FRAC) ? CENTRE_FRAC - FRAC_BITS : 0;
    localparam logic signed [WORD_W-1:0] FOUR    = 64'sd4 <<< FRAC_BITS;
    localparam logic signed [WORD_W-1:0] LIM_LO  = -(64'sd8 <<< FRAC_BITS);
    localparam logic signed [WORD_W-1:0] LIM_HI  = (64'sd8 <<< FRAC_BITS) - 64'sd1;
    localparam logic        [WORD_W-1:0] SAT16   = 64'd16 << FRAC_BITS;
    localparam logic signed [WORD_W-1:0] SEVEN_Q = 64'sd7 <<< (LOG_FRAC - 2);
    localparam logic signed [WORD_W-1:0] MAXPOS  = {1'b0, {(WORD_W-1){1'b1}}};

    localparam logic [1:0] MT_RI = 2'd0;
    localparam logic [1:0] MT_RR = 2'd1;
    localparam logic [1:0] MT_II = 2'd2;
    localparam logic [1:0] LT_L1 = 2'd0;
    localparam logic [1:0] LT_L2 = 2'd1;
    localparam logic [1:0] LT_L3 = 2'd2;
    localparam logic [1:0] LT_D  = 2'd3;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_MAPMUL  = 14'b00000000000010,
        S_MAPDEN  = 14'b00000000000100,
        S_MAPDIV  = 14'b00000000001000,
        S_MAPSUM  = 14'b00000000010000,
        S_ITCHK   = 14'b00000000100000,
        S_MUL     = 14'b00000001000000,
        S_MULDONE = 14'b00000010000000,
        S_MAGCHK  = 14'b00000100000000,
        S_LOGNORM = 14'b00001000000000,
        S_LOGSQ   = 14'b00010000000000,
        S_LOGDONE = 14'b00100000000000,
        S_BDIV    = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } t_state;

    // configuration
    logic [SIZE_W-1:0]    r_width, r_height;
    logic [31:0]          r_zoom, r_cre, r_cim;
    logic [ITER_BITS-1:0] r_limit;

    t_state r_state, n_state;
    logic [COORD_BITS-1:0] r_px, n_px, r_py, n_py;
    logic r_axis, n_axis, r_dneg, n_dneg;
    logic [SIZE_W-1:0] r_ad, n_ad;
    logic [DIV_W-1:0] r_q, n_q;
    logic signed [WORD_W-1:0] r_cr, n_cr, r_ci, n_ci, r_re, n_re, r_im, n_im;
    logic signed [WORD_W-1:0] r_rr, n_rr, r_ii, n_ii, r_nr, n_nr, r_mag, n_mag;
    logic signed [WORD_W-1:0] r_opa, n_opa, r_opb, n_opb;
    logic [ITER_BITS-1:0] r_i, n_i;
    logic r_mneg, n_mneg;
    logic [2*WORD_W-1:0] r_acc, n_acc;
    logic [2:0] r_mcnt, n_mcnt;
    logic [1:0] r_mtgt, n_mtgt, r_ltgt, n_ltgt;
    logic [WORD_W-1:0] r_lu, n_lu;
    logic [5:0] r_lsh, n_lsh, r_lfin, n_lfin;
    logic [30:0] r_lm, n_lm;
    logic [4:0] r_lk, n_lk;
    logic r_lph, n_lph;
    logic [LOG_FRAC-1:0] r_lfrac, n_lfrac;
    logic signed [LOG_W-1:0] r_l3, n_l3;
    logic [7:0] r_b, n_b;
    logic r_esc, n_esc;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // combinational helpers
    logic [SIZE_W-1:0] size_sel;
    logic [COORD_BITS-1:0] pix_sel;
    logic signed [SIZE_W+1:0] dpix;
    logic [SIZE_W+1:0] mult_ad;
    logic signed [WORD_W-1:0] cen_raw, cen_fix, vsum;
    logic [DIV_W-1:0] den;
    logic [WORD_W-1:0] ua, ub, mag_r;
    logic signed [WORD_W-1:0] mres, ni;
    logic [31:0] sq;
    logic signed [LOG_W-1:0] lres;
    logic signed [WORD_W-1:0] arg;
    logic [WORD_W-1:0] nb, dd;

    mps_mul32 u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    mps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(1920);
            r_height <= SIZE_W'(1080);
            r_zoom   <= 32'd65536;
            r_cre    <= 32'hF800_0000;
            r_cim    <= 32'd0;
            r_limit  <= ITER_BITS'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[SIZE_W-1:0];
                CFG_ZOOM:   r_zoom   <= i_cfg_data;
                CFG_CRE:    r_cre    <= i_cfg_data;
                CFG_CIM:    r_cim    <= i_cfg_data;
                CFG_LIMIT:  r_limit  <= i_cfg_data[ITER_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        size_sel = r_axis ? r_height : r_width;
        pix_sel  = r_axis ? r_py : r_px;
        dpix     = $signed({2'b00, SIZE_W'(pix_sel)}) - $signed({3'b000, size_sel[SIZE_W-1:1]});
        mult_ad  = r_axis ? {1'b0, r_ad, 1'b0} : ({1'b0, r_ad, 1'b0} + {2'b00, r_ad});
        cen_raw  = r_axis ? {{32{r_cim[31]}}, r_cim} : {{32{r_cre[31]}}, r_cre};
        cen_fix  = (cen_raw <<< CSHL) >>> CSHR;
        vsum     = (r_dneg ? -$signed(r_q) : $signed(r_q)) + cen_fix;
        den      = DIV_W'(mul_p);
        ua       = r_opa[WORD_W-1] ? WORD_W'(-r_opa) : WORD_W'(r_opa);
        ub       = r_opb[WORD_W-1] ? WORD_W'(-r_opb) : WORD_W'(r_opb);
        // product magnitude, shifted down and saturated
        mag_r    = (|r_acc[2*WORD_W-1:FRAC_BITS+WORD_W-1]) ? WORD_W'(MAXPOS)
                 : {1'b0, r_acc[FRAC_BITS+WORD_W-2:FRAC_BITS]};
        mres     = r_mneg ? -$signed(mag_r) : $signed(mag_r);
        ni       = sat_add(sat_add(mres, mres), r_ci);
        sq       = mul_p[61:30];
        lres     = LOG_W'((63 - int'(r_lsh) - int'(r_lfin)) * (1 << LOG_FRAC))
                 + $signed({{(LOG_W-LOG_FRAC){1'b0}}, r_lfrac});
        arg      = $signed({{(WORD_W-ITER_BITS-LOG_FRAC){1'b0}}, r_i, {LOG_FRAC{1'b0}}})
                 + SEVEN_Q - $signed({{(WORD_W-LOG_W){lres[LOG_W-1]}}, lres});
        nb       = ({{(WORD_W-LOG_W){1'b0}}, r_l3} << 8) - {{(WORD_W-LOG_W){1'b0}}, r_l3};
        dd       = {{(WORD_W-LOG_W){1'b0}}, lres};
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_MAPMUL: begin
                mul_a = r_zoom;
                mul_b = 32'(size_sel);
            end
            S_MUL: begin
                case (r_mcnt)
                    3'd0: begin mul_a = ua[31:0];  mul_b = ub[31:0];  end
                    3'd1: begin mul_a = ua[31:0];  mul_b = ub[63:32]; end
                    3'd2: begin mul_a = ua[63:32]; mul_b = ub[31:0];  end
                    3'd3: begin mul_a = ua[63:32]; mul_b = ub[63:32]; end
                    default: ;
                endcase
            end
            S_LOGSQ: begin
                mul_a = {1'b0, r_lm};
                mul_b = {1'b0, r_lm};
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state; n_px = r_px; n_py = r_py; n_axis = r_axis; n_dneg = r_dneg;
        n_ad = r_ad; n_q = r_q; n_cr = r_cr; n_ci = r_ci;
        n_re = r_re; n_im = r_im; n_rr = r_rr; n_ii = r_ii; n_nr = r_nr; n_mag = r_mag;
        n_opa = r_opa; n_opb = r_opb; n_i = r_i; n_mneg = r_mneg; n_acc = r_acc;
        n_mcnt = r_mcnt; n_mtgt = r_mtgt; n_ltgt = r_ltgt; n_lu = r_lu; n_lsh = r_lsh;
        n_lfin = r_lfin; n_lm = r_lm; n_lk = r_lk; n_lph = r_lph; n_lfrac = r_lfrac;
        n_l3 = r_l3; n_b = r_b; n_esc = r_esc;
        div_req = '0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_px    = s_axis_tdata[COORD_BITS-1:0];
                    n_py    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
                    n_axis  = 1'b0;
                    n_state = S_MAPMUL;
                end
            end
            S_MAPMUL: begin
                n_dneg  = dpix[SIZE_W+1];
                n_ad    = dpix[SIZE_W+1] ? SIZE_W'(-dpix) : SIZE_W'(dpix);
                n_state = S_MAPDEN;
            end
            S_MAPDEN: begin
                if (r_ad == '0) begin
                    n_q     = '0;
                    n_state = S_MAPSUM;
                end else if (den == '0 || (DIV_W'(mult_ad) << 16) >= (den << 4)) begin
                    n_q     = SAT16;
                    n_state = S_MAPSUM;
                end else begin
                    div_req.start = 1'b1;
                    div_req.rem   = DIV_W'(mult_ad) << 16;
                    div_req.dvs   = den << 3;
                    div_req.steps = STEP_W'(FRAC_BITS + 4);
                    n_state       = S_MAPDIV;
                end
            end
            S_MAPDIV: begin
                if (div_rsp.done) begin
                    n_q     = div_rsp.quot;
                    n_state = S_MAPSUM;
                end
            end
            S_MAPSUM: begin
                if (r_axis) begin
                    n_ci = (vsum < LIM_LO) ? LIM_LO : ((vsum > LIM_HI) ? LIM_HI : vsum);
                    n_re = '0; n_im = '0; n_rr = '0; n_ii = '0; n_i = '0;
                    n_state = S_ITCHK;
                end else begin
                    n_cr = (vsum < LIM_LO) ? LIM_LO : ((vsum > LIM_HI) ? LIM_HI : vsum);
                    n_axis  = 1'b1;
                    n_state = S_MAPMUL;
                end
            end
            S_ITCHK: begin
                if (r_i == r_limit) begin
                    n_esc   = 1'b0;
                    n_b     = '0;
                    n_state = S_OUT;
                end else begin
                    n_nr    = sat_add(sat_add(r_rr, -r_ii), r_cr);
                    n_opa   = r_re;
                    n_opb   = r_im;
                    n_mneg  = r_re[WORD_W-1] ^ r_im[WORD_W-1];
                    n_mcnt  = '0;
                    n_acc   = '0;
                    n_mtgt  = MT_RI;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // accumulate the product issued on the previous cycle
                case (r_mcnt)
                    3'd1: n_acc = r_acc + {64'd0, mul_p};
                    3'd2: n_acc = r_acc + {32'd0, mul_p, 32'd0};
                    3'd3: n_acc = r_acc + {32'd0, mul_p, 32'd0};
                    3'd4: n_acc = r_acc + {mul_p, 64'd0};
                    default: ;
                endcase
                n_mcnt = r_mcnt + 3'd1;
                if (r_mcnt == 3'd4) begin
                    n_state = S_MULDONE;
                end
            end
            S_MULDONE: begin
                n_mcnt  = '0;
                n_acc   = '0;
                n_state = S_MUL;
                case (r_mtgt)
                    MT_RI: begin
                        n_re   = r_nr;
                        n_im   = ni;
                        n_opa  = r_nr;
                        n_opb  = r_nr;
                        n_mneg = 1'b0;
                        n_mtgt = MT_RR;
                    end
                    MT_RR: begin
                        n_rr   = mres;
                        n_opa  = r_im;
                        n_opb  = r_im;
                        n_mneg = 1'b0;
                        n_mtgt = MT_II;
                    end
                    default: begin
                        n_ii    = mres;
                        n_mag   = sat_add(r_rr, mres);
                        n_state = S_MAGCHK;
                    end
                endcase
            end
            S_MAGCHK: begin
                if (r_mag > FOUR) begin
                    n_esc = 1'b1;
                    if (r_limit < ITER_BITS'(2)) begin
                        n_b     = 8'hFF;
                        n_state = S_OUT;
                    end else begin
                        n_lu    = WORD_W'(r_mag);
                        n_lsh   = '0;
                        n_lfin  = 6'(FRAC_BITS);
                        n_ltgt  = LT_L1;
                        n_state = S_LOGNORM;
                    end
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_ITCHK;
                end
            end
            S_LOGNORM: begin
                if (r_lu[WORD_W-1]) begin
                    n_lm    = r_lu[WORD_W-1:WORD_W-31];
                    n_lk    = '0;
                    n_lph   = 1'b0;
                    n_lfrac = '0;
                    n_state = S_LOGSQ;
                end else if (r_lu[WORD_W-1:WORD_W-8] == 8'd0) begin
                    n_lu  = r_lu << 8;
                    n_lsh = r_lsh + 6'd8;
                end else begin
                    n_lu  = r_lu << 1;
                    n_lsh = r_lsh + 6'd1;
                end
            end
            S_LOGSQ: begin
                n_lph = ~r_lph;
                if (r_lph) begin
                    n_lm    = sq[31] ? sq[31:1] : sq[30:0];
                    n_lfrac = {r_lfrac[LOG_FRAC-2:0], sq[31]};
                    n_lk    = r_lk + 5'd1;
                    if (r_lk == 5'(LOG_FRAC - 1)) begin
                        n_state = S_LOGDONE;
                    end
                end
            end
            S_LOGDONE: begin
                n_lsh = '0;
                case (r_ltgt)
                    LT_L1: begin
                        n_lu    = {{(WORD_W-LOG_W){1'b0}}, lres};
                        n_lfin  = 6'(LOG_FRAC + 1);
                        n_ltgt  = LT_L2;
                        n_state = S_LOGNORM;
                    end
                    LT_L2: begin
                        if (arg <= 0) begin
                            n_b     = '0;
                            n_state = S_OUT;
                        end else begin
                            n_lu    = WORD_W'(arg);
                            n_lfin  = 6'(LOG_FRAC);
                            n_ltgt  = LT_L3;
                            n_state = S_LOGNORM;
                        end
                    end
                    LT_L3: begin
                        if (lres <= 0) begin
                            n_b     = '0;
                            n_state = S_OUT;
                        end else begin
                            n_l3    = lres;
                            n_lu    = WORD_W'(r_limit);
                            n_lfin  = '0;
                            n_ltgt  = LT_D;
                            n_state = S_LOGNORM;
                        end
                    end
                    default: begin
                        if (nb >= (dd << 8)) begin
                            n_b     = 8'hFF;
                            n_state = S_OUT;
                        end else begin
                            div_req.start = 1'b1;
                            div_req.rem   = nb;
                            div_req.dvs   = dd << 7;
                            div_req.steps = STEP_W'(8);
                            n_state       = S_BDIV;
                        end
                    end
                endcase
            end
            S_BDIV: begin
                if (div_rsp.done) begin
                    n_b     = div_rsp.quot[7:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= n_px; r_py <= n_py; r_axis <= n_axis; r_dneg <= n_dneg; r_ad <= n_ad;
        r_q <= n_q; r_cr <= n_cr; r_ci <= n_ci; r_re <= n_re;
        r_im <= n_im; r_rr <= n_rr; r_ii <= n_ii; r_nr <= n_nr; r_mag <= n_mag;
        r_opa <= n_opa; r_opb <= n_opb; r_i <= n_i; r_mneg <= n_mneg; r_acc <= n_acc;
        r_mcnt <= n_mcnt; r_mtgt <= n_mtgt; r_ltgt <= n_ltgt; r_lu <= n_lu;
        r_lsh <= n_lsh; r_lfin <= n_lfin; r_lm <= n_lm; r_lk <= n_lk; r_lph <= n_lph;
        r_lfrac <= n_lfrac; r_l3 <= n_l3; r_b <= n_b; r_esc <= n_esc;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_esc;
    assign m_axis_tdata  = OUT_W'({r_i, (r_esc ? {8'h00, r_b, r_b, 8'hFF} : 32'h0)});
endmodule
`default_nettype wire

/* design/mps_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mps_checker
// port-level checks on the pixel shader input and result streams
// ----------------------------------------------------------------------------
`include "mandelbrot_pixel_shader_macros.svh"

module mps_checker #(
    parameter int OUT_W = 56
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata,
    input wire logic             m_axis_tuser
);
    `MPS_ASSERT_IMP(a_inside_black, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[31:0] == 32'd0)
    `MPS_ASSERT_IMP(a_grey_packing, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[7:0] == 8'hFF && m_axis_tdata[15:8] == m_axis_tdata[23:16] && m_axis_tdata[31:24] == 8'h00)
    `MPS_ASSERT_IMP(a_one_in_flight, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `MPS_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `MPS_ASSERT_NXT(a_result_held, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind mandelbrot_pixel_shader mps_checker #(.OUT_W(OUT_W)) u_mps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
